// ===== design/pgrms_pkg.sv =====
// Package with the shared constants, types and state codes of the level meter.
`timescale 1ns / 1ps
`default_nettype none
package pgrms_pkg;
	// Field and state widths.
	localparam int unsigned SAMPLE_W    = 16;
	localparam int unsigned CNT_W       = 21;
	localparam int unsigned SUM_W       = 51;
	localparam int unsigned SQ_W        = 31;
	localparam int unsigned MAX_SAMPLES = 1048576;

	// Summary queue between the accumulator and the root unit.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = 2;
	localparam int unsigned QLVL_W = 3;

	// The quotient is below 2^31, so the divide runs over 31 bits and the root over 16 digits.
	localparam int unsigned QUO_W      = 31;
	localparam int unsigned RAD_W      = 32;
	localparam int unsigned DIV_STEPS  = 31;
	localparam int unsigned SQRT_STEPS = 16;
	localparam int unsigned STEP_W     = 5;

	// One finished block as handed from the front to the back.
	typedef struct packed {
		logic [SUM_W-1:0]    sum;
		logic [SAMPLE_W-1:0] peak;
		logic [CNT_W-1:0]    pos;
		logic [CNT_W-1:0]    total;
		logic                ovf;
	} summary_t;

	// Queue status seen by the front.
	typedef struct packed {
		logic [QLVL_W-1:0] level;
		logic              empty;
	} q_status_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_SQRT
	} back_state_t;
endpackage
`default_nettype wire

// ===== design/pgrms_front.sv =====
// Front end: takes samples, gates and squares them, and keeps the running block state.
`timescale 1ns / 1ps
`default_nettype none
module pgrms_front import pgrms_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic                last,
	input  wire logic                cfg_valid,
	input  wire logic [SAMPLE_W-1:0] cfg_data,
	input  wire q_status_t           q_stat,
	output logic                     busy,
	output logic                     push,
	output summary_t                 push_word
);
	logic [SAMPLE_W-1:0] gate_q;
	logic                v_s1, last_s1, v_s2, last_s2;
	logic [SAMPLE_W-1:0] mag_s1, mag_s2;
	logic [SQ_W-1:0]     sq_s2;
	logic [SUM_W-1:0]    sum_q, sum_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [SAMPLE_W-1:0] peak_q, peak_d;
	logic [CNT_W-1:0]    pos_q, pos_d;
	logic                ovf_q, ovf_d;
	logic                accept;
	logic [SAMPLE_W-1:0] mag_in;
	logic [2*SAMPLE_W-1:0] prod;
	logic [QLVL_W-1:0]   reserved;

	// A word is taken unless the queue could not hold every block end already in flight.
	assign reserved = q_stat.level + QLVL_W'(v_s1 & last_s1) + QLVL_W'(v_s2 & last_s2);
	assign busy     = (reserved >= QLVL_W'(QDEPTH));
	assign accept   = start & ~busy;

	// Magnitude of the two's complement sample; the most negative code gives 32768.
	assign mag_in = sample[SAMPLE_W-1] ? (~sample + SAMPLE_W'(1)) : sample;
	assign prod   = mag_s1 * mag_s1;

	// Gate threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q <= '0;
		end else if (cfg_valid) begin
			gate_q <= cfg_data;
		end
	end

	// Two stage pipeline: magnitude, then gated square.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1  <= mag_in;
		last_s1 <= last;
		mag_s2  <= mag_s1;
		last_s2 <= last_s1;
		sq_s2   <= (mag_s1 > gate_q) ? prod[SQ_W-1:0] : '0;
	end

	// Block state update; samples past the limit only raise the overflow flag.
	always_comb begin
		sum_d  = sum_q;
		cnt_d  = cnt_q;
		peak_d = peak_q;
		pos_d  = pos_q;
		ovf_d  = ovf_q;
		if (v_s2) begin
			if (cnt_q < CNT_W'(MAX_SAMPLES)) begin
				cnt_d = cnt_q + CNT_W'(1);
				sum_d = sum_q + SUM_W'(sq_s2);
				if (mag_s2 > peak_q) begin
					peak_d = mag_s2;
					pos_d  = cnt_q + CNT_W'(1);
				end
			end else begin
				ovf_d = 1'b1;
			end
		end
	end

	assign push            = v_s2 & last_s2;
	assign push_word.sum   = sum_d;
	assign push_word.peak  = peak_d;
	assign push_word.pos   = pos_d;
	assign push_word.total = cnt_d;
	assign push_word.ovf   = ovf_d;

	// The state clears once a block summary has been queued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			cnt_q  <= '0;
			peak_q <= '0;
			pos_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (push) begin
			sum_q  <= '0;
			cnt_q  <= '0;
			peak_q <= '0;
			pos_q  <= '0;
			ovf_q  <= 1'b0;
		end else begin
			sum_q  <= sum_d;
			cnt_q  <= cnt_d;
			peak_q <= peak_d;
			pos_q  <= pos_d;
			ovf_q  <= ovf_d;
		end
	end

	// The sample count never passes the block limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count beyond limit");
endmodule
`default_nettype wire

// ===== design/pgrms_queue.sv =====
// Short queue of block summaries between the accumulator and the root unit.
`timescale 1ns / 1ps
`default_nettype none
module pgrms_queue import pgrms_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire summary_t push_word,
	input  wire logic     pop,
	output summary_t      head,
	output q_status_t     q_stat
);
	summary_t          mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QLVL_W-1:0] level_q;

	// Storage is written at the tail.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_word;
		end
	end

	assign head         = mem[rd_ptr_q];
	assign q_stat.level = level_q;
	assign q_stat.empty = (level_q == '0);

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			level_q <= level_q + QLVL_W'(push) - QLVL_W'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (level_q != QLVL_W'(QDEPTH)) || pop)
		else $error("summary pushed into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (level_q != '0))
		else $error("summary popped from an empty queue");
endmodule
`default_nettype wire

// ===== design/pgrms_back.sv =====
// Back end: divides the gated sum by the count and takes the integer square root.
`timescale 1ns / 1ps
`default_nettype none
module pgrms_back import pgrms_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire summary_t            head,
	input  wire q_status_t           q_stat,
	output logic                     pop,
	output logic                     done,
	output logic [SAMPLE_W-1:0]      peak_level,
	output logic [CNT_W-1:0]         peak_position,
	output logic [SAMPLE_W-1:0]      rms_level,
	output logic [CNT_W-1:0]         sample_total,
	output logic                     overflow
);
	back_state_t         state_q, state_d;
	logic [STEP_W-1:0]   step_q;
	logic                done_q;
	logic [CNT_W-1:0]    rem_q, rem_d;
	logic [QUO_W-1:0]    dvd_q, quo_q;
	logic [CNT_W-1:0]    total_q, pos_q;
	logic [SAMPLE_W-1:0] peak_q, root_q, rms_q;
	logic                ovf_q;
	logic [RAD_W-1:0]    rad_q;
	logic [SAMPLE_W+2:0] srem_q, srem_d;
	logic [CNT_W:0]      div_trial;
	logic                div_ge;
	logic [SAMPLE_W+2:0] sq_acc, sq_trial;
	logic                sq_ge;
	logic                div_end, sqrt_end;

	assign div_end  = (step_q == STEP_W'(DIV_STEPS - 1));
	assign sqrt_end = (step_q == STEP_W'(SQRT_STEPS - 1));

	// Sequencer: take a summary, run the divide, then the root.
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					state_d = B_DIV;
				end
			end
			B_DIV: begin
				if (div_end) begin
					state_d = B_SQRT;
				end
			end
			B_SQRT: begin
				if (sqrt_end) begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == B_SQRT) && sqrt_end;
			if (state_q == B_IDLE || (state_q == B_DIV && div_end)) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// Restoring divide step: one quotient bit a cycle.
	assign div_trial = {rem_q, dvd_q[QUO_W-1]};
	assign div_ge    = (div_trial >= {1'b0, total_q});
	assign rem_d     = div_ge ? CNT_W'(div_trial - {1'b0, total_q}) : div_trial[CNT_W-1:0];

	// Digit by digit root step: two radicand bits a cycle.
	assign sq_acc   = {srem_q[SAMPLE_W:0], rad_q[RAD_W-1 -: 2]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign sq_ge    = (sq_acc >= sq_trial);
	assign srem_d   = sq_ge ? (sq_acc - sq_trial) : sq_acc;

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				rem_q   <= CNT_W'(head.sum[SUM_W-1:QUO_W]);
				dvd_q   <= head.sum[QUO_W-1:0];
				quo_q   <= '0;
				total_q <= head.total;
				peak_q  <= head.peak;
				pos_q   <= head.pos;
				ovf_q   <= head.ovf;
			end
			B_DIV: begin
				rem_q  <= rem_d;
				dvd_q  <= {dvd_q[QUO_W-2:0], 1'b0};
				quo_q  <= {quo_q[QUO_W-2:0], div_ge};
				rad_q  <= {1'b0, quo_q[QUO_W-2:0], div_ge};
				srem_q <= '0;
				root_q <= '0;
			end
			B_SQRT: begin
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				srem_q <= srem_d;
				root_q <= {root_q[SAMPLE_W-2:0], sq_ge};
				rms_q  <= {root_q[SAMPLE_W-2:0], sq_ge};
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign done          = done_q;
	assign peak_level    = peak_q;
	assign peak_position = pos_q;
	assign rms_level     = rms_q;
	assign sample_total  = total_q;
	assign overflow      = ovf_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result word strobed in consecutive cycles");
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rms_q <= peak_q))
		else $error("rms level above peak level");
endmodule
`default_nettype wire

// ===== design/peak_and_gated_rms_meter_unit.sv =====
// Top level of the peak and gated RMS level meter.
// A sample word is taken in a cycle with start high and busy low; a block streams at one word a cycle
// while busy stays low. The result word is strobed on done once the last sample has passed
// the two pipeline stages, the summary queue, the divide and then the square root.
// The back end takes one block at a time, so a run of short blocks fills the four entry queue and busy
// then holds samples off. Reset clears the gate threshold, block state and queue; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module peak_and_gated_rms_meter_unit import pgrms_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic                last,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [SAMPLE_W-1:0] cfg_data,
	output logic                     done,
	output logic [SAMPLE_W-1:0]      peak_level,
	output logic [CNT_W-1:0]         peak_position,
	output logic [SAMPLE_W-1:0]      rms_level,
	output logic [CNT_W-1:0]         sample_total,
	output logic                     overflow
);
	logic      push, pop;
	summary_t  push_word, head;
	q_status_t q_stat;

	// The threshold register takes a word in any cycle.
	assign cfg_ready = 1'b1;

	pgrms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.sample    (sample),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.busy      (busy),
		.push      (push),
		.push_word (push_word)
	);

	pgrms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	pgrms_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_stat        (q_stat),
		.pop           (pop),
		.done          (done),
		.peak_level    (peak_level),
		.peak_position (peak_position),
		.rms_level     (rms_level),
		.sample_total  (sample_total),
		.overflow      (overflow)
	);
endmodule
`default_nettype wire

// ===== dv/peak_and_gated_rms_meter_checker.sv =====
// Checker for the level meter: predicts every block summary and compares it with the result word.
`timescale 1ns / 1ps
module peak_and_gated_rms_meter_checker import pgrms_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                busy,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic                last,
	input  wire logic                cfg_valid,
	input  wire logic                cfg_ready,
	input  wire logic [SAMPLE_W-1:0] cfg_data,
	input  wire logic                done,
	input  wire logic [SAMPLE_W-1:0] peak_level,
	input  wire logic [CNT_W-1:0]    peak_position,
	input  wire logic [SAMPLE_W-1:0] rms_level,
	input  wire logic [CNT_W-1:0]    sample_total,
	input  wire logic                overflow,
	output int                       fail_count,
	output int                       readings_due
);

	// One block summary as the meter should report it.
	typedef struct packed {
		logic [SAMPLE_W-1:0] peak;
		logic [CNT_W-1:0]    pos;
		logic [SAMPLE_W-1:0] rms;
		logic [CNT_W-1:0]    total;
		logic                ovf;
	} meter_reading_t;

	meter_reading_t      expected_readings[$];
	logic [SAMPLE_W-1:0] gate_level;
	logic [SUM_W-1:0]    gated_energy;
	logic [CNT_W-1:0]    samples_taken;
	logic [SAMPLE_W-1:0] peak_so_far;
	logic [CNT_W-1:0]    peak_at;
	logic                excess_seen;

	// Integer square root, built up one result bit at a time from the top.
	function automatic logic [SAMPLE_W-1:0] floor_root(input logic [SUM_W-1:0] q);
		logic [SAMPLE_W-1:0] r;
		logic [SAMPLE_W-1:0] trial;
		logic [63:0]         prod;
		r = '0;
		for (int b = SAMPLE_W - 1; b >= 0; b--) begin
			trial = r | (16'd1 << b);
			prod = 64'(trial) * 64'(trial);
			if (prod <= 64'(q))
				r = trial;
		end
		return r;
	endfunction

	// Fold one accepted sample word into the running block and close the block on last.
	task automatic absorb_sample(input logic [SAMPLE_W-1:0] s, input logic l);
		logic [SAMPLE_W-1:0] mag;
		logic [31:0]         sq;
		meter_reading_t      r;
		mag = s[SAMPLE_W-1] ? (~s + 16'd1) : s;
		sq = 32'(mag) * 32'(mag);
		if (samples_taken < MAX_SAMPLES) begin
			samples_taken = samples_taken + 1'b1;
			if (mag > gate_level)
				gated_energy = gated_energy + SUM_W'(sq);
			if (mag > peak_so_far) begin
				peak_so_far = mag;
				peak_at = samples_taken;
			end
		end else begin
			excess_seen = 1'b1;
		end
		if (l) begin
			r.peak = peak_so_far;
			r.pos = peak_at;
			r.rms = (samples_taken != 0) ? floor_root(gated_energy / samples_taken) : '0;
			r.total = samples_taken;
			r.ovf = excess_seen;
			expected_readings.push_back(r);
			gated_energy = '0;
			samples_taken = '0;
			peak_so_far = '0;
			peak_at = '0;
			excess_seen = 1'b0;
		end
	endtask

	// Compare each strobed result word with the oldest prediction.
	task automatic check_reading();
		meter_reading_t e;
		if (expected_readings.size() == 0) begin
			$display("%0t: unexpected result word: peak %0d at %0d, rms %0d, total %0d, ovf %0d",
				$time, peak_level, peak_position, rms_level, sample_total, overflow);
			fail_count++;
			return;
		end
		e = expected_readings.pop_front();
		if (peak_level !== e.peak) begin
			$display("%0t: peak_level expected %0d, got %0d", $time, e.peak, peak_level);
			fail_count++;
		end
		if (peak_position !== e.pos) begin
			$display("%0t: peak_position expected %0d, got %0d", $time, e.pos, peak_position);
			fail_count++;
		end
		if (rms_level !== e.rms) begin
			$display("%0t: rms_level expected %0d, got %0d", $time, e.rms, rms_level);
			fail_count++;
		end
		if (sample_total !== e.total) begin
			$display("%0t: sample_total expected %0d, got %0d", $time, e.total, sample_total);
			fail_count++;
		end
		if (overflow !== e.ovf) begin
			$display("%0t: overflow expected %0d, got %0d", $time, e.ovf, overflow);
			fail_count++;
		end
	endtask

	initial fail_count = 0;

	// Watch the sample, configuration and result channels at every rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_readings.delete();
			gate_level = '0;
			gated_energy = '0;
			samples_taken = '0;
			peak_so_far = '0;
			peak_at = '0;
			excess_seen = 1'b0;
			readings_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				gate_level = cfg_data;
			if (start && !busy)
				absorb_sample(sample, last);
			if (done)
				check_reading();
			readings_due <= expected_readings.size();
		end
	end

endmodule

// ===== dv/tb_peak_and_gated_rms_meter_unit.sv =====
// Testbench top for the level meter: clock, reset, sample and gate stimulus, and the verdict.
`timescale 1ns / 1ps
module tb_peak_and_gated_rms_meter_unit;
	import pgrms_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PHASE_WORDS = 105;

	// Content styles for a generated block.
	typedef enum int {
		BLK_MIXED,
		BLK_SILENT,
		BLK_QUIET
	} block_kind_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [SAMPLE_W-1:0] sample = '0;
	logic                last = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [SAMPLE_W-1:0] cfg_data = '0;
	logic                done;
	logic [SAMPLE_W-1:0] peak_level;
	logic [CNT_W-1:0]    peak_position;
	logic [SAMPLE_W-1:0] rms_level;
	logic [CNT_W-1:0]    sample_total;
	logic                overflow;
	int                  fail_count;
	int                  readings_due;
	int unsigned         cycle_count = 0;
	int unsigned         words_sent = 0;
	logic [SAMPLE_W-1:0] gate_setting = '0;

	peak_and_gated_rms_meter_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sample(sample), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .peak_level(peak_level), .peak_position(peak_position),
		.rms_level(rms_level), .sample_total(sample_total), .overflow(overflow)
	);

	peak_and_gated_rms_meter_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sample(sample), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .peak_level(peak_level), .peak_position(peak_position),
		.rms_level(rms_level), .sample_total(sample_total), .overflow(overflow),
		.fail_count(fail_count), .readings_due(readings_due)
	);

	// Free-running 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[peak_and_gated_rms_meter_unit] ERROR");
			$finish;
		end
	end

	// Present one sample word after an optional random gap and hold it until it is taken.
	task automatic put_word(input logic [SAMPLE_W-1:0] s, input logic l,
			input int unsigned idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		sample <= s;
		last <= l;
		do @(posedge clk); while (busy);
		words_sent++;
	endtask

	// Wait until every block summary has come back and the back end has gone quiet.
	task automatic drain_meter();
		start <= 1'b0;
		@(posedge clk);
		while (readings_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Change the gate threshold once the meter is idle.
	task automatic set_gate(input logic [SAMPLE_W-1:0] v);
		drain_meter();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gate_setting = v;
	endtask

	// Pick one sample, leaning on the extremes and on magnitudes around the gate.
	function automatic logic [SAMPLE_W-1:0] pick_sample(input block_kind_t kind);
		int unsigned         m;
		int unsigned         g;
		logic [SAMPLE_W-1:0] s;
		g = (gate_setting > 16'd32768) ? 32768 : gate_setting;
		m = 0;
		if (kind == BLK_SILENT)
			return '0;
		if (kind == BLK_QUIET) begin
			m = $urandom_range(0, g);
		end else begin
			case ($urandom_range(0, 9))
				0: m = 32768;
				1: m = 32767;
				2: m = 0;
				3: m = g;
				4: m = g + 1;
				5: m = (g == 0) ? 0 : g - 1;
				6, 7: return SAMPLE_W'($urandom);
				default: m = $urandom_range(0, 300);
			endcase
		end
		if (m > 32768)
			m = 32768;
		s = m[SAMPLE_W-1:0];
		if ($urandom_range(0, 1) == 1)
			s = -s;
		return s;
	endfunction

	// Send one block of the given style and length, last flagged on its final word.
	task automatic send_block(input block_kind_t kind, input int unsigned len,
			input int unsigned idle_pct);
		for (int unsigned i = 0; i < len; i++)
			put_word(pick_sample(kind), i == len - 1, idle_pct);
	endtask

	// Random block with a short length most of the time, never longer than max_len.
	task automatic send_random_block(input int unsigned idle_pct, input int unsigned max_len);
		block_kind_t kind;
		int unsigned len;
		case ($urandom_range(0, 9))
			0: kind = BLK_SILENT;
			1: kind = BLK_QUIET;
			default: kind = BLK_MIXED;
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: len = $urandom_range(1, 8);
			6, 7, 8: len = $urandom_range(9, 40);
			default: len = $urandom_range(41, 200);
		endcase
		if (len > max_len)
			len = max_len;
		send_block(kind, len, idle_pct);
	endtask

	// Directed blocks, then random phases at several gates and gap rates.
	initial begin
		int unsigned idle_pct;
		int unsigned phase_end;
		logic [SAMPLE_W-1:0] g;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Gate at its reset value: extremes, a silent block and ties on the peak.
		put_word(16'h8000, 1'b1, 0);
		put_word(16'h7FFF, 1'b1, 0);
		put_word(16'h0000, 1'b0, 0);
		put_word(16'h0000, 1'b0, 0);
		put_word(16'h0000, 1'b1, 0);
		put_word(16'd5, 1'b0, 0);
		put_word(-16'd5, 1'b0, 0);
		put_word(16'd7, 1'b0, 0);
		put_word(-16'd7, 1'b1, 0);
		put_word(16'd1, 1'b0, 0);
		put_word(16'hFFFF, 1'b1, 0);

		// Gate at its top values: nothing can pass, so the level must read zero.
		set_gate(16'd32768);
		put_word(16'h8000, 1'b0, 0);
		put_word(16'h7FFF, 1'b0, 0);
		put_word(16'd100, 1'b1, 0);
		set_gate(16'hFFFF);
		put_word(16'h8000, 1'b0, 0);
		put_word(16'h7FFF, 1'b1, 0);

		// Magnitudes on either side of the gate.
		set_gate(16'd100);
		put_word(16'd100, 1'b0, 0);
		put_word(-16'd101, 1'b0, 0);
		put_word(16'd99, 1'b0, 0);
		put_word(16'd101, 1'b0, 0);
		put_word(-16'd100, 1'b1, 0);

		// Random phases, each setting its own gate and a gap rate.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: g = SAMPLE_W'($urandom_range(0, 2000));
				1: g = SAMPLE_W'($urandom_range(0, 32768));
				2: g = '0;
				3: g = SAMPLE_W'($urandom);
				default: g = SAMPLE_W'($urandom_range(200, 400));
			endcase
			case (ph)
				1, 3: idle_pct = 72;
				2: idle_pct = 20;
				default: idle_pct = 0;
			endcase
			set_gate(g);
			phase_end = words_sent + PHASE_WORDS;
			while (words_sent < phase_end)
				send_random_block(idle_pct, phase_end - words_sent);
		end

		drain_meter();
		if (fail_count == 0 && readings_due == 0)
			$display("[peak_and_gated_rms_meter_unit] OK");
		else
			$display("[peak_and_gated_rms_meter_unit] ERROR");
		$finish;
	end

endmodule
